// ===== rtl/blgi_pkg.sv =====
// Shared codes and decode helpers for the boiler link gateway interceptor.
// No dependencies; imported by boiler_link_gateway_interceptor.
package blgi_pkg;

  // Item function codes
  localparam logic [2:0] FUNC_REQ      = 3'd0;
  localparam logic [2:0] FUNC_RSP      = 3'd1;
  localparam logic [2:0] FUNC_REQ_TMO  = 3'd2;
  localparam logic [2:0] FUNC_RSP_TMO  = 3'd3;
  localparam logic [2:0] FUNC_READ     = 3'd4;
  localparam logic [2:0] FUNC_CLEAR    = 3'd5;

  // Data identifiers
  localparam logic [7:0] ID_STATUS       = 8'd0;
  localparam logic [7:0] ID_HEAT_SET     = 8'd1;
  localparam logic [7:0] ID_WATER_SET    = 8'd56;
  localparam logic [7:0] ID_ROOM_TEMP    = 8'd24;
  localparam logic [7:0] ID_MODULATION   = 8'd17;
  localparam logic [7:0] ID_FLOW_TEMP    = 8'd25;
  localparam logic [7:0] ID_TAP_TEMP     = 8'd26;
  localparam logic [7:0] ID_OUTDOOR_TEMP = 8'd27;

  // Shadow index, also change flag bit position
  localparam logic [7:0] SH_HEAT_EN    = 8'd0;
  localparam logic [7:0] SH_WATER_EN   = 8'd1;
  localparam logic [7:0] SH_HEAT_SET   = 8'd2;
  localparam logic [7:0] SH_WATER_SET  = 8'd3;
  localparam logic [7:0] SH_ROOM_TEMP  = 8'd4;
  localparam logic [7:0] SH_THERM_LIVE = 8'd5;
  localparam logic [7:0] SH_FAULT      = 8'd6;
  localparam logic [7:0] SH_HEAT_ON    = 8'd7;
  localparam logic [7:0] SH_WATER_ON   = 8'd8;
  localparam logic [7:0] SH_FLAME_ON   = 8'd9;
  localparam logic [7:0] SH_MODULATION = 8'd10;
  localparam logic [7:0] SH_FLOW_TEMP  = 8'd11;
  localparam logic [7:0] SH_TAP_TEMP   = 8'd12;
  localparam logic [7:0] SH_OUTDOOR    = 8'd13;
  localparam logic [7:0] SH_BOIL_LIVE  = 8'd14;

  localparam int FLAG_W = 15;

  // Word memory slots
  localparam logic [2:0] WS_HEAT_SET   = 3'd0;
  localparam logic [2:0] WS_WATER_SET  = 3'd1;
  localparam logic [2:0] WS_ROOM_TEMP  = 3'd2;
  localparam logic [2:0] WS_MODULATION = 3'd3;
  localparam logic [2:0] WS_FLOW_TEMP  = 3'd4;
  localparam logic [2:0] WS_TAP_TEMP   = 3'd5;
  localparam logic [2:0] WS_OUTDOOR    = 3'd6;
  localparam int         WS_DEPTH      = 8;

  // Single-bit shadow positions in the bit register
  localparam logic [2:0] BS_HEAT_EN    = 3'd0;
  localparam logic [2:0] BS_WATER_EN   = 3'd1;
  localparam logic [2:0] BS_THERM_LIVE = 3'd2;
  localparam logic [2:0] BS_FAULT      = 3'd3;
  localparam logic [2:0] BS_HEAT_ON    = 3'd4;
  localparam logic [2:0] BS_WATER_ON   = 3'd5;
  localparam logic [2:0] BS_FLAME_ON   = 3'd6;
  localparam logic [2:0] BS_BOIL_LIVE  = 3'd7;

  // Configuration register indexes
  localparam logic [2:0] REG_RELAY_MODE     = 3'd0;
  localparam logic [2:0] REG_HEAT_OVR       = 3'd1;
  localparam logic [2:0] REG_WATER_OVR      = 3'd2;
  localparam logic [2:0] REG_FORCED_HEAT_EN = 3'd3;
  localparam logic [2:0] REG_FORCED_WATER_EN = 3'd4;
  localparam logic [2:0] REG_FORCED_HEAT_SP = 3'd5;
  localparam logic [2:0] REG_FORCED_WATER_SP = 3'd6;

  typedef struct packed {
    logic       hit;
    logic [2:0] slot;
  } slot_t;

  // Which word memory slot an item touches, if any
  function automatic slot_t word_slot(input logic [2:0] func, input logic [7:0] id);
    slot_t s;
    s.hit  = 1'b1;
    s.slot = WS_HEAT_SET;
    if (func == FUNC_REQ) begin
      if (id == ID_HEAT_SET)       s.slot = WS_HEAT_SET;
      else if (id == ID_WATER_SET) s.slot = WS_WATER_SET;
      else if (id == ID_ROOM_TEMP) s.slot = WS_ROOM_TEMP;
      else                         s.hit  = 1'b0;
    end else if (func == FUNC_RSP) begin
      if (id == ID_MODULATION)        s.slot = WS_MODULATION;
      else if (id == ID_FLOW_TEMP)    s.slot = WS_FLOW_TEMP;
      else if (id == ID_TAP_TEMP)     s.slot = WS_TAP_TEMP;
      else if (id == ID_OUTDOOR_TEMP) s.slot = WS_OUTDOOR;
      else                            s.hit  = 1'b0;
    end else if (func == FUNC_READ) begin
      if (id == SH_HEAT_SET)        s.slot = WS_HEAT_SET;
      else if (id == SH_WATER_SET)  s.slot = WS_WATER_SET;
      else if (id == SH_ROOM_TEMP)  s.slot = WS_ROOM_TEMP;
      else if (id == SH_MODULATION) s.slot = WS_MODULATION;
      else if (id == SH_FLOW_TEMP)  s.slot = WS_FLOW_TEMP;
      else if (id == SH_TAP_TEMP)   s.slot = WS_TAP_TEMP;
      else if (id == SH_OUTDOOR)    s.slot = WS_OUTDOOR;
      else                          s.hit  = 1'b0;
    end else begin
      s.hit = 1'b0;
    end
    return s;
  endfunction

  // Change flag bit owned by a word slot
  function automatic logic [3:0] slot_flag(input logic [2:0] slot);
    logic [3:0] f;
    case (slot)
      WS_HEAT_SET:   f = SH_HEAT_SET[3:0];
      WS_WATER_SET:  f = SH_WATER_SET[3:0];
      WS_ROOM_TEMP:  f = SH_ROOM_TEMP[3:0];
      WS_MODULATION: f = SH_MODULATION[3:0];
      WS_FLOW_TEMP:  f = SH_FLOW_TEMP[3:0];
      WS_TAP_TEMP:   f = SH_TAP_TEMP[3:0];
      WS_OUTDOOR:    f = SH_OUTDOOR[3:0];
      default:       f = SH_HEAT_SET[3:0];
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/boiler_link_gateway_interceptor.sv =====
// Boiler link gateway interceptor: frame rewrite, shadow capture and link health.
// Depends on blgi_pkg.
//
// Takes one item per clock unless the output stalls and returns one result per
// item via the second stage and the output register. Word shadows (setpoints
// and temperatures) live in an 8 x 16 synchronous memory read at acceptance
// and written back from the second stage; a write-to-read forward covers an
// item that touches the slot written by the item just ahead of it. Single-bit
// shadows, miss counters and change flags are flip-flops. Memory entries that
// were never written read as zero through per-slot valid bits, so no clearing
// pass follows reset. Configuration registers sit on an APB port at 4*index.
module boiler_link_gateway_interceptor
  import blgi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [2:0]  frame_type_i,
  input  logic [7:0]  frame_id_i,
  input  logic [7:0]  value_high_i,
  input  logic [7:0]  value_low_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        send_valid_o,
  output logic        send_to_thermostat_o,
  output logic [2:0]  send_type_o,
  output logic [7:0]  send_id_o,
  output logic [7:0]  send_high_o,
  output logic [7:0]  send_low_o,
  output logic [15:0] read_value_o,
  output logic [14:0] changed_mask_o,
  output logic        thermostat_online_o,
  output logic        boiler_online_o
);

  // ---------------- configuration ----------------
  logic        relay_mode_q, heat_ovr_q, water_ovr_q, forced_heat_en_q, forced_water_en_q;
  logic [15:0] forced_heat_sp_q, forced_water_sp_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relay_mode_q      <= 1'b0;
      heat_ovr_q        <= 1'b0;
      water_ovr_q       <= 1'b0;
      forced_heat_en_q  <= 1'b0;
      forced_water_en_q <= 1'b0;
      forced_heat_sp_q  <= '0;
      forced_water_sp_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_RELAY_MODE:      relay_mode_q      <= pwdata[0];
        REG_HEAT_OVR:        heat_ovr_q        <= pwdata[0];
        REG_WATER_OVR:       water_ovr_q       <= pwdata[0];
        REG_FORCED_HEAT_EN:  forced_heat_en_q  <= pwdata[0];
        REG_FORCED_WATER_EN: forced_water_en_q <= pwdata[0];
        REG_FORCED_HEAT_SP:  forced_heat_sp_q  <= pwdata[15:0];
        REG_FORCED_WATER_SP: forced_water_sp_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_RELAY_MODE:      prdata = {31'd0, relay_mode_q};
      REG_HEAT_OVR:        prdata = {31'd0, heat_ovr_q};
      REG_WATER_OVR:       prdata = {31'd0, water_ovr_q};
      REG_FORCED_HEAT_EN:  prdata = {31'd0, forced_heat_en_q};
      REG_FORCED_WATER_EN: prdata = {31'd0, forced_water_en_q};
      REG_FORCED_HEAT_SP:  prdata = {16'd0, forced_heat_sp_q};
      REG_FORCED_WATER_SP: prdata = {16'd0, forced_water_sp_q};
      default:             prdata = '0;
    endcase
  end

  // ---------------- stage 0: accept and memory read ----------------
  logic        accept;
  logic        s1_valid_q, s1_fire, out_hold;
  logic [2:0]  s1_func_q, s1_type_q;
  logic [7:0]  s1_id_q, s1_hi_q, s1_lo_q;
  slot_t       in_slot, s1_slot_q;
  logic [15:0] word_mem_q [WS_DEPTH];
  logic [WS_DEPTH-1:0] word_vld_q;
  logic [15:0] rdata_q;
  logic        fwd_hit_q;
  logic [15:0] fwd_data_q;
  logic        wr_en;
  logic [15:0] s1_word;

  assign out_hold   = out_valid_o && out_stall_i;
  assign in_stall_o = s1_valid_q && out_hold;
  assign accept     = in_valid_i && !in_stall_o;
  assign s1_fire    = s1_valid_q && !out_hold;
  assign in_slot    = word_slot(func_i, frame_id_i);
  assign s1_word    = {s1_hi_q, s1_lo_q};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q   <= word_mem_q[in_slot.slot];
      s1_func_q <= func_i;
      s1_type_q <= frame_type_i;
      s1_id_q   <= frame_id_i;
      s1_hi_q   <= value_high_i;
      s1_lo_q   <= value_low_i;
      s1_slot_q <= in_slot;
      fwd_data_q <= s1_word;
    end
    if (s1_fire && wr_en) begin
      word_mem_q[s1_slot_q.slot] <= s1_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
      word_vld_q <= '0;
    end else begin
      if (accept)       s1_valid_q <= 1'b1;
      else if (s1_fire) s1_valid_q <= 1'b0;
      // new item reads a slot that is being written at this same edge
      if (accept) begin
        fwd_hit_q <= s1_fire && wr_en && in_slot.hit && s1_slot_q.hit &&
                     (in_slot.slot == s1_slot_q.slot);
      end else if (s1_fire) begin
        fwd_hit_q <= 1'b0;
      end
      if (s1_fire && wr_en) word_vld_q[s1_slot_q.slot] <= 1'b1;
    end
  end

  // ---------------- stage 1: modify, write back, form result ----------------
  logic [7:0]        bits_q, bits_d;
  logic [1:0]        tmiss_q, tmiss_d, bmiss_q, bmiss_d;
  logic [FLAG_W-1:0] flags_q, flags_d;
  logic [15:0]       old_word, rd_val;
  logic              sv, sto;
  logic [7:0]        sh, sl;

  always_comb begin
    if (fwd_hit_q)                          old_word = fwd_data_q;
    else if (word_vld_q[s1_slot_q.slot])    old_word = rdata_q;
    else                                    old_word = '0;
  end

  always_comb begin
    bits_d  = bits_q;
    tmiss_d = tmiss_q;
    bmiss_d = bmiss_q;
    flags_d = flags_q;
    wr_en   = 1'b0;
    sv      = 1'b0;
    sto     = 1'b0;
    sh      = s1_hi_q;
    sl      = s1_lo_q;
    rd_val  = '0;
    case (s1_func_q)
      FUNC_REQ: begin
        sv = 1'b1;
        if (s1_id_q == ID_STATUS) begin
          if (heat_ovr_q) begin
            sh[0] = forced_heat_en_q;
          end else if (bits_d[BS_HEAT_EN] != s1_hi_q[0]) begin
            bits_d[BS_HEAT_EN]      = s1_hi_q[0];
            flags_d[SH_HEAT_EN[3:0]] = 1'b1;
          end
          if (water_ovr_q) begin
            sh[1] = forced_water_en_q;
          end else if (bits_d[BS_WATER_EN] != s1_hi_q[1]) begin
            bits_d[BS_WATER_EN]       = s1_hi_q[1];
            flags_d[SH_WATER_EN[3:0]] = 1'b1;
          end
        end else if (s1_id_q == ID_HEAT_SET && heat_ovr_q) begin
          sh = forced_heat_sp_q[15:8];
          sl = forced_heat_sp_q[7:0];
        end else if (s1_id_q == ID_WATER_SET && water_ovr_q) begin
          sh = forced_water_sp_q[15:8];
          sl = forced_water_sp_q[7:0];
        end else if (s1_slot_q.hit) begin
          wr_en = 1'b1;
        end
        if (!bits_d[BS_THERM_LIVE]) begin
          bits_d[BS_THERM_LIVE]       = 1'b1;
          flags_d[SH_THERM_LIVE[3:0]] = 1'b1;
        end
        tmiss_d = '0;
      end
      FUNC_RSP: begin
        if (s1_id_q == ID_STATUS) begin
          if (bits_d[BS_FAULT] != s1_lo_q[0]) begin
            bits_d[BS_FAULT]       = s1_lo_q[0];
            flags_d[SH_FAULT[3:0]] = 1'b1;
          end
          if (bits_d[BS_HEAT_ON] != s1_lo_q[1]) begin
            bits_d[BS_HEAT_ON]       = s1_lo_q[1];
            flags_d[SH_HEAT_ON[3:0]] = 1'b1;
          end
          if (bits_d[BS_WATER_ON] != s1_lo_q[2]) begin
            bits_d[BS_WATER_ON]       = s1_lo_q[2];
            flags_d[SH_WATER_ON[3:0]] = 1'b1;
          end
          if (bits_d[BS_FLAME_ON] != s1_lo_q[3]) begin
            bits_d[BS_FLAME_ON]       = s1_lo_q[3];
            flags_d[SH_FLAME_ON[3:0]] = 1'b1;
          end
        end else if (s1_slot_q.hit) begin
          wr_en = 1'b1;
        end
        if (!bits_d[BS_BOIL_LIVE]) begin
          bits_d[BS_BOIL_LIVE]       = 1'b1;
          flags_d[SH_BOIL_LIVE[3:0]] = 1'b1;
        end
        bmiss_d = '0;
        sv      = !relay_mode_q;
        sto     = !relay_mode_q;
      end
      FUNC_REQ_TMO: begin
        if (tmiss_q > 2'd1 && bits_d[BS_THERM_LIVE]) begin
          bits_d[BS_THERM_LIVE]       = 1'b0;
          flags_d[SH_THERM_LIVE[3:0]] = 1'b1;
        end
        if (tmiss_q != 2'd3) tmiss_d = tmiss_q + 2'd1;
      end
      FUNC_RSP_TMO: begin
        if (bmiss_q > 2'd1 && bits_d[BS_BOIL_LIVE]) begin
          bits_d[BS_BOIL_LIVE]       = 1'b0;
          flags_d[SH_BOIL_LIVE[3:0]] = 1'b1;
        end
        if (bmiss_q != 2'd3) bmiss_d = bmiss_q + 2'd1;
      end
      FUNC_READ: begin
        if (s1_slot_q.hit) begin
          rd_val = old_word;
        end else begin
          case (s1_id_q)
            SH_HEAT_EN:    rd_val = {15'd0, bits_q[BS_HEAT_EN]};
            SH_WATER_EN:   rd_val = {15'd0, bits_q[BS_WATER_EN]};
            SH_THERM_LIVE: rd_val = {15'd0, bits_q[BS_THERM_LIVE]};
            SH_FAULT:      rd_val = {15'd0, bits_q[BS_FAULT]};
            SH_HEAT_ON:    rd_val = {15'd0, bits_q[BS_HEAT_ON]};
            SH_WATER_ON:   rd_val = {15'd0, bits_q[BS_WATER_ON]};
            SH_FLAME_ON:   rd_val = {15'd0, bits_q[BS_FLAME_ON]};
            SH_BOIL_LIVE:  rd_val = {15'd0, bits_q[BS_BOIL_LIVE]};
            default:       rd_val = '0;
          endcase
        end
      end
      FUNC_CLEAR: begin
        flags_d = flags_q & ~s1_word[FLAG_W-1:0];
      end
      default: ;
    endcase
    // word capture: flag only on a real change
    if (wr_en && (s1_word != old_word)) flags_d[slot_flag(s1_slot_q.slot)] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q  <= '0;
      tmiss_q <= '0;
      bmiss_q <= '0;
      flags_q <= '0;
    end else if (s1_fire) begin
      bits_q  <= bits_d;
      tmiss_q <= tmiss_d;
      bmiss_q <= bmiss_d;
      flags_q <= flags_d;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s1_fire) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      send_valid_o         <= sv;
      send_to_thermostat_o <= sv && sto;
      send_type_o          <= sv ? s1_type_q : 3'd0;
      send_id_o            <= sv ? s1_id_q : 8'd0;
      send_high_o          <= sv ? sh : 8'd0;
      send_low_o           <= sv ? sl : 8'd0;
      read_value_o         <= rd_val;
      changed_mask_o       <= flags_d;
      thermostat_online_o  <= bits_d[BS_THERM_LIVE];
      boiler_online_o      <= bits_d[BS_BOIL_LIVE];
    end
  end

  // ---------------- assertions ----------------
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with no item in flight");

  a_fwd_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> s1_valid_q)
    else $error("forward marked with no item in flight");

  a_req_sets_online: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && send_valid_o && !send_to_thermostat_o) |-> thermostat_online_o)
    else $error("forwarded request without thermostat online");

  a_rsp_sets_online: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && send_valid_o && send_to_thermostat_o) |-> boiler_online_o)
    else $error("forwarded response without boiler online");

endmodule
